@@ hw/rtl/radio_offset_sweep_tuner_macros.svh @@
// assertion macros shared by the offset sweep tuner modules
// expects signals named clock and reset in the module that uses them
`ifndef RADIO_OFFSET_SWEEP_TUNER_MACROS_SVH
`define RADIO_OFFSET_SWEEP_TUNER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ROST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ROST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/rost_pkg.sv @@
// shared types and constants for the radio offset sweep tuner
// no dependencies
package rost_pkg;

   // widths of the offset fields and of the csr data and index
   localparam int unsigned OFS_W  = 8;
   localparam int unsigned CSR_W  = 7;
   localparam int unsigned CSR_IDX_W = 1;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_COARSE_STEP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FINE_MARGIN = 1'b1;

   // register reset values
   localparam logic [CSR_W-1:0] COARSE_STEP_RST = 7'd9;
   localparam logic [CSR_W-1:0] FINE_MARGIN_RST = 7'd9;

   // sweep constants
   localparam logic signed [OFS_W-1:0] COARSE_START = -8'sd127;
   localparam logic signed [OFS_W-1:0] COARSE_LIMIT = 8'sd117;
   localparam logic signed [OFS_W-1:0] LOW_GOOD_RST = 8'sd127;
   localparam logic signed [OFS_W-1:0] HIGH_GOOD_RST = -8'sd127;

   // item commands
   typedef enum logic [1:0] {
      MODE_RESTART = 2'd0,
      MODE_ADVANCE = 2'd1,
      MODE_TRIAL   = 2'd2,
      MODE_FINISH  = 2'd3
   } mode_type;

   // one input item
   typedef struct packed {
      mode_type mode;
      logic     bind_seen;
   } item_type;

   // one result item
   typedef struct packed {
      logic signed [OFS_W-1:0] offset;
      logic                    done_res;
      logic                    found;
      logic signed [OFS_W-1:0] midpoint;
   } result_type;

endpackage

@@ hw/rtl/radio_offset_sweep_tuner.sv @@
// top level of the radio offset sweep tuner: handshake, item and result registers, csrs
// depends on rost_pkg, rost_tracker and radio_offset_sweep_tuner_macros.svh
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  req     | in        | req_valid/req_stall | req_mode, req_bind_seen
//  rsp     | out       | rsp_valid/rsp_stall | rsp_offset, rsp_done_res, rsp_found,
//          |           |                    | rsp_midpoint
//  csr     | in        | csr_we             | csr_index, csr_wdata
//
// one item per cycle sustained while rsp_stall is low; a result is presented once its item
// has moved from the item register into the result register
// reset is synchronous: search state cleared, coarse_step and fine_margin back to 9
// rsp_stall holds the result register; the item register still fills behind it
// req_stall rises only when the item register is full and the result cannot move
`include "radio_offset_sweep_tuner_macros.svh"

module radio_offset_sweep_tuner import rost_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_mode,
   input  logic                    req_bind_seen,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OFS_W-1:0] rsp_offset,
   output logic                    rsp_done_res,
   output logic                    rsp_found,
   output logic signed [OFS_W-1:0] rsp_midpoint,
   // configuration port
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   logic             in_valid_ff, in_valid_in;
   item_type         in_item_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff;
   logic [CSR_W-1:0] coarse_step_ff;
   logic [CSR_W-1:0] fine_margin_ff;

   logic       out_free;
   logic       step_en;
   logic       req_take;
   result_type step_result;

   // flow control between the two stages
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_en) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.mode      <= mode_type'(req_mode);
         in_item_ff.bind_seen <= req_bind_seen;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= step_result;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coarse_step_ff <= COARSE_STEP_RST;
         fine_margin_ff <= FINE_MARGIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COARSE_STEP: coarse_step_ff <= csr_wdata;
            CSR_FINE_MARGIN: fine_margin_ff <= csr_wdata;
            default: begin
               coarse_step_ff <= coarse_step_ff;
            end
         endcase
      end
   end

   // sweep state and per-item update
   rost_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .item        (in_item_ff),
      .coarse_step (coarse_step_ff),
      .fine_margin (fine_margin_ff),
      .result      (step_result)
   );

   // outputs
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_offset   = rsp_data_ff.offset;
   assign rsp_done_res = rsp_data_ff.done_res;
   assign rsp_found    = rsp_data_ff.found;
   assign rsp_midpoint = rsp_data_ff.midpoint;

   // a held item is never overwritten while the result side is blocked
   `ROST_ASSERT_NOW(a_no_overwrite, in_valid_ff && !out_free, req_stall, "held item overwritten")
   // a finished search always has a working offset behind it
   `ROST_ASSERT_NOW(a_done_found, rsp_valid_ff && rsp_done_res, rsp_found, "done without found")
   // an update always leaves a result behind it
   `ROST_ASSERT_NEXT(a_step_result, step_en, rsp_valid_ff, "update produced no result")

endmodule

@@ hw/rtl/rost_tracker.sv @@
// search state of the offset sweep: phase, current offset, good range
// depends on rost_pkg and radio_offset_sweep_tuner_macros.svh
`include "radio_offset_sweep_tuner_macros.svh"

module rost_tracker import rost_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  item_type         item,
   input  logic [CSR_W-1:0] coarse_step,
   input  logic [CSR_W-1:0] fine_margin,
   output result_type       result
);

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_COARSE = 2'd1,
      PH_FINE   = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   localparam int unsigned WIDE_W = OFS_W + 2;

   phase_type               phase_ff, phase_in;
   logic signed [OFS_W-1:0] offset_ff, offset_in;
   logic signed [OFS_W-1:0] low_ff, low_in;
   logic signed [OFS_W-1:0] high_ff, high_in;
   logic                    seen_ff, seen_in;

   logic signed [WIDE_W-1:0] coarse_sum;
   logic signed [WIDE_W-1:0] fine_low_sum;
   logic signed [WIDE_W-1:0] fine_high_sum;
   logic signed [OFS_W-1:0]  coarse_next;
   logic signed [OFS_W-1:0]  fine_first;
   logic signed [OFS_W-1:0]  fine_last;
   logic signed [OFS_W-1:0]  mid_now;
   logic signed [OFS_W-1:0]  mid_next;

   // clamp a widened sum into the signed offset range
   function automatic logic signed [OFS_W-1:0] sat_ofs(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(signed'({1'b0, {(OFS_W-1){1'b1}}}));
      lo = -hi - WIDE_W'(1);
      if (v > hi) begin
         sat_ofs = hi[OFS_W-1:0];
      end else if (v < lo) begin
         sat_ofs = lo[OFS_W-1:0];
      end else begin
         sat_ofs = v[OFS_W-1:0];
      end
   endfunction

   // (a + b) / 2 rounded toward zero
   function automatic logic signed [OFS_W-1:0] mid_of(input logic signed [OFS_W-1:0] a,
                                                       input logic signed [OFS_W-1:0] b);
      logic signed [OFS_W:0] s;
      logic signed [OFS_W:0] adj;
      s   = {a[OFS_W-1], a} + {b[OFS_W-1], b};
      adj = s + {{OFS_W{1'b0}}, s[OFS_W]};
      mid_of = adj[OFS_W:1];
   endfunction

   // step candidates
   assign coarse_sum    = WIDE_W'(offset_ff) + $signed({3'b0, coarse_step});
   assign fine_low_sum  = WIDE_W'(low_ff) - $signed({3'b0, fine_margin});
   assign fine_high_sum = WIDE_W'(high_ff) + $signed({3'b0, fine_margin});
   assign coarse_next   = sat_ofs(coarse_sum);
   assign fine_first    = sat_ofs(fine_low_sum);
   assign fine_last     = sat_ofs(fine_high_sum);
   assign mid_now       = mid_of(high_ff, low_ff);

   // next state for the item in hand
   always_comb begin
      phase_in  = phase_ff;
      offset_in = offset_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      seen_in   = seen_ff;
      case (item.mode)
         MODE_RESTART: begin
            phase_in  = PH_START;
            offset_in = '0;
            low_in    = LOW_GOOD_RST;
            high_in   = HIGH_GOOD_RST;
            seen_in   = 1'b0;
         end
         MODE_ADVANCE: begin
            case (phase_ff)
               PH_COARSE: begin
                  if (offset_ff < COARSE_LIMIT) begin
                     offset_in = coarse_next;
                  end else if (seen_ff) begin
                     offset_in = fine_first;
                     phase_in  = PH_FINE;
                  end else begin
                     phase_in  = PH_START;
                  end
               end
               PH_FINE: begin
                  if (offset_ff < fine_last) begin
                     offset_in = offset_ff + 8'sd1;
                  end else begin
                     phase_in  = PH_DONE;
                  end
               end
               default: begin
                  offset_in = COARSE_START;
                  phase_in  = PH_COARSE;
               end
            endcase
         end
         MODE_TRIAL: begin
            if (item.bind_seen) begin
               seen_in = 1'b1;
               if (offset_ff < low_ff) begin
                  low_in = offset_ff;
               end
               if (offset_ff > high_ff) begin
                  high_in = offset_ff;
               end
            end
         end
         MODE_FINISH: begin
            offset_in = mid_now;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // result reflects the state after the item
   assign mid_next = mid_of(high_in, low_in);
   always_comb begin
      result.offset   = offset_in;
      result.done_res = (phase_in == PH_DONE);
      result.found    = seen_in;
      result.midpoint = mid_next;
   end

   // search state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         offset_ff <= '0;
         low_ff    <= LOW_GOOD_RST;
         high_ff   <= HIGH_GOOD_RST;
         seen_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
         seen_ff   <= seen_in;
      end
   end

   // fine pass and done are only reached once something was seen
   `ROST_ASSERT_NOW(a_fine_needs_seen, (phase_ff == PH_FINE) || (phase_ff == PH_DONE), seen_ff, "fine pass without a seen packet")
   // a recorded range is never inverted
   `ROST_ASSERT_NOW(a_range_order, seen_ff, low_ff <= high_ff, "good range inverted")
   // restart puts the sweep back at its start
   `ROST_ASSERT_NEXT(a_restart_clears, step_en && (item.mode == MODE_RESTART), (phase_ff == PH_START) && (offset_ff == '0) && !seen_ff, "restart did not clear state")

endmodule
